### rtl/bcfd_pkg.sv
`timescale 1ns / 1ps
package bcfd_pkg;

   // defaults for the top level parameters
   localparam int SLOTS_DEF       = 32;
   localparam int BLOCK_BYTES_DEF = 4096;

   // fixed field widths
   localparam int MODE_W = 3;
   localparam int FILE_W = 8;
   localparam int POS_W  = 31;
   localparam int LEN_W  = 16;
   localparam int KIND_W = 3;
   localparam int CTR_W  = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REPORT = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DONE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WB    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FILL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PF    = 3'd4;

   typedef enum logic [2:0] {
      OP_READ, OP_WRITE, OP_FLUSH, OP_CLOSE, OP_REPORT, OP_NONE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [FILE_W-1:0] file;
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
   } req_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_EVICT, ST_PLACE, ST_PF_LOOK, ST_WALK, ST_DONE
   } state_type;

endpackage

### rtl/block_cache_fifo_directory.sv
`timescale 1ns / 1ps
// channel   ports        moves
// request   req_*        mode, file_id, byte_position, request_length
// response  rsp_*        kind, out_file, block_number, slot_index, offset,
//                        bytes_granted, was_hit, hits_seen, misses_seen, last
//
// A read or write runs through the back sequencer: lookup, an optional
// eviction and placement, for reads a prefetch lookup of the next block
// with its own optional eviction and placement, and the done word. Flush
// and close walk every slot, one per cycle unless a writeback word waits on
// a stalled response register; report and unknown modes go to the done word.
// Reset is synchronous and empties the directory; a two-word queue lets
// requests land while the sequencer waits on a stalled response register.
module block_cache_fifo_directory #(
   parameter int SLOTS       = bcfd_pkg::SLOTS_DEF,
   parameter int BLOCK_BYTES = bcfd_pkg::BLOCK_BYTES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [bcfd_pkg::MODE_W-1:0]            req_mode,
   input  logic [bcfd_pkg::FILE_W-1:0]            req_file_id,
   input  logic [bcfd_pkg::POS_W-1:0]             req_byte_position,
   input  logic [bcfd_pkg::LEN_W-1:0]             req_request_length,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [bcfd_pkg::KIND_W-1:0]            rsp_kind,
   output logic [bcfd_pkg::FILE_W-1:0]            rsp_out_file,
   output logic [bcfd_pkg::POS_W-$clog2(BLOCK_BYTES)-1:0] rsp_block_number,
   output logic [$clog2(SLOTS)-1:0]               rsp_slot_index,
   output logic [$clog2(BLOCK_BYTES)-1:0]         rsp_offset_in_block,
   output logic [$clog2(BLOCK_BYTES):0]           rsp_bytes_granted,
   output logic                                   rsp_was_hit,
   output logic [bcfd_pkg::CTR_W-1:0]             rsp_hits_seen,
   output logic [bcfd_pkg::CTR_W-1:0]             rsp_misses_seen,
   output logic                                   rsp_last
);

   logic              q_valid, q_pop;
   bcfd_pkg::req_type q_word;

   bcfd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_file_id,
      .req_byte_position, .req_request_length, .q_valid, .q_pop, .q_word
   );

   bcfd_back #(.SLOTS(SLOTS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_word, .rsp_valid, .rsp_ready,
      .rsp_kind, .rsp_out_file, .rsp_block_number, .rsp_slot_index,
      .rsp_offset_in_block, .rsp_bytes_granted, .rsp_was_hit,
      .rsp_hits_seen, .rsp_misses_seen, .rsp_last
   );

endmodule

### rtl/bcfd_front.sv
`timescale 1ns / 1ps
module bcfd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bcfd_pkg::MODE_W-1:0]   req_mode,
   input  logic [bcfd_pkg::FILE_W-1:0]   req_file_id,
   input  logic [bcfd_pkg::POS_W-1:0]    req_byte_position,
   input  logic [bcfd_pkg::LEN_W-1:0]    req_request_length,
   output logic                          q_valid,
   input  logic                          q_pop,
   output bcfd_pkg::req_type             q_word
);

   bcfd_pkg::req_type ent_ff [2];
   bcfd_pkg::req_type word_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   // classify the mode
   always_comb begin
      word_in.file = req_file_id;
      word_in.pos  = req_byte_position;
      word_in.len  = req_request_length;
      case (req_mode)
         bcfd_pkg::MODE_READ:   word_in.op = bcfd_pkg::OP_READ;
         bcfd_pkg::MODE_WRITE:  word_in.op = bcfd_pkg::OP_WRITE;
         bcfd_pkg::MODE_FLUSH:  word_in.op = bcfd_pkg::OP_FLUSH;
         bcfd_pkg::MODE_CLOSE:  word_in.op = bcfd_pkg::OP_CLOSE;
         bcfd_pkg::MODE_REPORT: word_in.op = bcfd_pkg::OP_REPORT;
         default:               word_in.op = bcfd_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_word    = ent_ff[0];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(q_pop && q_valid)) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // shift the two-entry queue
   always_ff @(posedge clock) begin
      if (q_pop && q_valid) begin
         ent_ff[0] <= ent_ff[1];
         if (push && cnt_ff == 2'd1) ent_ff[0] <= word_in;
         else if (push) ent_ff[1] <= word_in;
      end else if (push) begin
         if (cnt_ff == 2'd0) ent_ff[0] <= word_in;
         else ent_ff[1] <= word_in;
      end
   end

endmodule

### rtl/bcfd_back.sv
`timescale 1ns / 1ps
module bcfd_back #(
   parameter int SLOTS       = bcfd_pkg::SLOTS_DEF,
   parameter int BLOCK_BYTES = bcfd_pkg::BLOCK_BYTES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   output logic                                   q_pop,
   input  bcfd_pkg::req_type                      q_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [bcfd_pkg::KIND_W-1:0]            rsp_kind,
   output logic [bcfd_pkg::FILE_W-1:0]            rsp_out_file,
   output logic [bcfd_pkg::POS_W-$clog2(BLOCK_BYTES)-1:0] rsp_block_number,
   output logic [$clog2(SLOTS)-1:0]               rsp_slot_index,
   output logic [$clog2(BLOCK_BYTES)-1:0]         rsp_offset_in_block,
   output logic [$clog2(BLOCK_BYTES):0]           rsp_bytes_granted,
   output logic                                   rsp_was_hit,
   output logic [bcfd_pkg::CTR_W-1:0]             rsp_hits_seen,
   output logic [bcfd_pkg::CTR_W-1:0]             rsp_misses_seen,
   output logic                                   rsp_last
);

   localparam int OFF_W = $clog2(BLOCK_BYTES);
   localparam int BLK_W = bcfd_pkg::POS_W - OFF_W;
   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int GW    = (OFF_W + 1 > bcfd_pkg::LEN_W) ? OFF_W + 1 : bcfd_pkg::LEN_W;
   localparam logic [CW-1:0] FULL = CW'(SLOTS);
   localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
   localparam logic [GW-1:0] BB_G = GW'(BLOCK_BYTES);

   // directory
   logic                      valid_ff [SLOTS];
   logic                      dirty_ff [SLOTS];
   logic [bcfd_pkg::FILE_W-1:0] file_ff [SLOTS];
   logic [BLK_W-1:0]          blk_ff   [SLOTS];
   logic [SW-1:0]             rank_ff  [SLOTS];
   logic                      valid_in [SLOTS];
   logic                      dirty_in [SLOTS];
   logic [SW-1:0]             rank_in  [SLOTS];
   logic [CW-1:0]             count_ff, count_in;
   logic [bcfd_pkg::CTR_W-1:0] hits_ff, hits_in, miss_ff, miss_in;

   // current request
   bcfd_pkg::state_type       state_ff, state_in;
   bcfd_pkg::op_type          op_ff, op_in;
   logic [bcfd_pkg::FILE_W-1:0] kfile_ff, kfile_in;
   logic [BLK_W-1:0]          kblk_ff, kblk_in, rblk_ff, rblk_in;
   logic [OFF_W-1:0]          off_ff, off_in;
   logic [OFF_W:0]            grant_ff, grant_in;
   logic                      hit_ff, hit_in, pf_ff, pf_in;
   logic [SW-1:0]             s_ff, s_in, idx_ff, idx_in;

   // output register
   logic                      ov_ff, ov_in;
   logic [bcfd_pkg::KIND_W-1:0] okind_ff, okind_in;
   logic [bcfd_pkg::FILE_W-1:0] ofile_ff, ofile_in;
   logic [BLK_W-1:0]          oblk_ff, oblk_in;
   logic [SW-1:0]             oslot_ff, oslot_in;
   logic [OFF_W-1:0]          ooff_ff, ooff_in;
   logic [OFF_W:0]            ogr_ff, ogr_in;
   logic                      ohit_ff, ohit_in, olast_ff, olast_in;
   logic [bcfd_pkg::CTR_W-1:0] ohs_ff, ohs_in, oms_ff, oms_in;

   // search results
   logic              match_any;
   logic [SW-1:0]     match_idx, free_idx, old_idx;
   logic              out_free, emit;
   logic              do_write, do_unlink;
   logic [SW-1:0]     wr_idx, un_idx;
   logic [GW-1:0]     left_g, len_g;

   assign out_free = !ov_ff || rsp_ready;

   // look up the key and pick the free and oldest slots
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      old_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && file_ff[i] == kfile_ff && blk_ff[i] == kblk_ff) begin
            match_any = 1'b1;
            match_idx = SW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = SW'(i);
         end
         if (valid_ff[i] && rank_ff[i] == '0) old_idx = SW'(i);
      end
   end

   // sequence the request
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      kfile_in = kfile_ff;
      kblk_in  = kblk_ff;
      rblk_in  = rblk_ff;
      off_in   = off_ff;
      grant_in = grant_ff;
      hit_in   = hit_ff;
      pf_in    = pf_ff;
      s_in     = s_ff;
      idx_in   = idx_ff;
      hits_in  = hits_ff;
      miss_in  = miss_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      do_write = 1'b0;
      wr_idx   = free_idx;
      do_unlink = 1'b0;
      un_idx   = old_idx;
      for (int i = 0; i < SLOTS; i++) dirty_in[i] = dirty_ff[i];
      okind_in = bcfd_pkg::KIND_DONE;
      ofile_in = kfile_ff;
      oblk_in  = '0;
      oslot_in = '0;
      ooff_in  = '0;
      ogr_in   = '0;
      ohit_in  = 1'b0;
      ohs_in   = '0;
      oms_in   = '0;
      olast_in = 1'b0;
      left_g   = BB_G - GW'(q_word.pos[OFF_W-1:0]);
      len_g    = GW'(q_word.len);

      case (state_ff)
         bcfd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_word.op;
               kfile_in = q_word.file;
               kblk_in  = q_word.pos[bcfd_pkg::POS_W-1:OFF_W];
               rblk_in  = q_word.pos[bcfd_pkg::POS_W-1:OFF_W];
               off_in   = q_word.pos[OFF_W-1:0];
               grant_in = (len_g < left_g) ? len_g[OFF_W:0] : left_g[OFF_W:0];
               idx_in   = '0;
               pf_in    = 1'b0;
               case (q_word.op)
                  bcfd_pkg::OP_READ, bcfd_pkg::OP_WRITE: state_in = bcfd_pkg::ST_LOOK;
                  bcfd_pkg::OP_FLUSH, bcfd_pkg::OP_CLOSE: state_in = bcfd_pkg::ST_WALK;
                  default: state_in = bcfd_pkg::ST_DONE;
               endcase
            end
         end
         bcfd_pkg::ST_LOOK: begin
            hit_in = match_any;
            if (match_any) begin
               if (hits_ff != '1) hits_in = hits_ff + 1'b1;
               s_in = match_idx;
               if (op_ff == bcfd_pkg::OP_WRITE) begin
                  dirty_in[match_idx] = 1'b1;
                  state_in = bcfd_pkg::ST_DONE;
               end else if (rblk_ff == '1) begin
                  state_in = bcfd_pkg::ST_DONE;
               end else begin
                  kblk_in  = rblk_ff + 1'b1;
                  pf_in    = 1'b1;
                  state_in = bcfd_pkg::ST_PF_LOOK;
               end
            end else begin
               if (miss_ff != '1) miss_in = miss_ff + 1'b1;
               state_in = (count_ff == FULL) ? bcfd_pkg::ST_EVICT : bcfd_pkg::ST_PLACE;
            end
         end
         bcfd_pkg::ST_PF_LOOK: begin
            if (match_any) state_in = bcfd_pkg::ST_DONE;
            else state_in = (count_ff == FULL) ? bcfd_pkg::ST_EVICT : bcfd_pkg::ST_PLACE;
         end
         bcfd_pkg::ST_EVICT: begin
            // write back the oldest block if dirty, then drop it
            okind_in = bcfd_pkg::KIND_WB;
            ofile_in = file_ff[old_idx];
            oblk_in  = blk_ff[old_idx];
            oslot_in = old_idx;
            if (!dirty_ff[old_idx] || out_free) begin
               emit      = dirty_ff[old_idx];
               do_unlink = 1'b1;
               state_in  = bcfd_pkg::ST_PLACE;
            end
         end
         bcfd_pkg::ST_PLACE: begin
            okind_in = pf_ff ? bcfd_pkg::KIND_PF :
                       (op_ff == bcfd_pkg::OP_READ) ? bcfd_pkg::KIND_FILL : bcfd_pkg::KIND_ALLOC;
            oblk_in  = kblk_ff;
            oslot_in = free_idx;
            if (out_free) begin
               emit     = 1'b1;
               do_write = 1'b1;
               dirty_in[free_idx] = !pf_ff && (op_ff == bcfd_pkg::OP_WRITE);
               if (pf_ff) begin
                  state_in = bcfd_pkg::ST_DONE;
               end else begin
                  s_in = free_idx;
                  if (op_ff == bcfd_pkg::OP_READ && rblk_ff != '1) begin
                     kblk_in  = rblk_ff + 1'b1;
                     pf_in    = 1'b1;
                     state_in = bcfd_pkg::ST_PF_LOOK;
                  end else begin
                     state_in = bcfd_pkg::ST_DONE;
                  end
               end
            end
         end
         bcfd_pkg::ST_WALK: begin
            // one slot a cycle, bar stalls: write back dirty, free on close
            okind_in = bcfd_pkg::KIND_WB;
            oblk_in  = blk_ff[idx_ff];
            oslot_in = idx_ff;
            un_idx   = idx_ff;
            if (valid_ff[idx_ff] && file_ff[idx_ff] == kfile_ff) begin
               if (!dirty_ff[idx_ff] || out_free) begin
                  emit = dirty_ff[idx_ff];
                  dirty_in[idx_ff] = 1'b0;
                  do_unlink = (op_ff == bcfd_pkg::OP_CLOSE);
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == LAST_IDX) state_in = bcfd_pkg::ST_DONE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) state_in = bcfd_pkg::ST_DONE;
            end
         end
         bcfd_pkg::ST_DONE: begin
            okind_in = bcfd_pkg::KIND_DONE;
            olast_in = 1'b1;
            case (op_ff)
               bcfd_pkg::OP_READ, bcfd_pkg::OP_WRITE: begin
                  oblk_in  = rblk_ff;
                  oslot_in = s_ff;
                  ooff_in  = off_ff;
                  ogr_in   = grant_ff;
                  ohit_in  = hit_ff;
               end
               bcfd_pkg::OP_REPORT: begin
                  ofile_in = '0;
                  ohs_in   = hits_ff;
                  oms_in   = miss_ff;
               end
               default: ;
            endcase
            if (out_free) begin
               emit     = 1'b1;
               state_in = bcfd_pkg::ST_IDLE;
               if (op_ff == bcfd_pkg::OP_REPORT) begin
                  hits_in = '0;
                  miss_in = '0;
               end
            end
         end
         default: state_in = bcfd_pkg::ST_IDLE;
      endcase

      if (do_unlink) dirty_in[un_idx] = 1'b0;
   end

   // update valid bits, ranks and the fill count
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < SLOTS; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (do_unlink) begin
         for (int i = 0; i < SLOTS; i++)
            if (valid_ff[i] && rank_ff[i] > rank_ff[un_idx]) rank_in[i] = rank_ff[i] - 1'b1;
         valid_in[un_idx] = 1'b0;
         rank_in[un_idx]  = '0;
         count_in = count_ff - 1'b1;
      end
      if (do_write) begin
         valid_in[wr_idx] = 1'b1;
         rank_in[wr_idx]  = count_ff[SW-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (emit) ov_in = 1'b1;
      else if (rsp_ready) ov_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcfd_pkg::ST_IDLE;
         count_ff <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         ov_ff    <= ov_in;
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= valid_in[i];
            dirty_ff[i] <= dirty_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

   // hold tags and request payload
   always_ff @(posedge clock) begin
      if (do_write) begin
         file_ff[wr_idx] <= kfile_ff;
         blk_ff[wr_idx]  <= kblk_ff;
      end
      op_ff    <= op_in;
      kfile_ff <= kfile_in;
      kblk_ff  <= kblk_in;
      rblk_ff  <= rblk_in;
      off_ff   <= off_in;
      grant_ff <= grant_in;
      hit_ff   <= hit_in;
      pf_ff    <= pf_in;
      s_ff     <= s_in;
      idx_ff   <= idx_in;
      if (emit) begin
         okind_ff <= okind_in;
         ofile_ff <= ofile_in;
         oblk_ff  <= oblk_in;
         oslot_ff <= oslot_in;
         ooff_ff  <= ooff_in;
         ogr_ff   <= ogr_in;
         ohit_ff  <= ohit_in;
         ohs_ff   <= ohs_in;
         oms_ff   <= oms_in;
         olast_ff <= olast_in;
      end
   end

   assign rsp_valid           = ov_ff;
   assign rsp_kind            = okind_ff;
   assign rsp_out_file        = ofile_ff;
   assign rsp_block_number    = oblk_ff;
   assign rsp_slot_index      = oslot_ff;
   assign rsp_offset_in_block = ooff_ff;
   assign rsp_bytes_granted   = ogr_ff;
   assign rsp_was_hit         = ohit_ff;
   assign rsp_hits_seen       = ohs_ff;
   assign rsp_misses_seen     = oms_ff;
   assign rsp_last            = olast_ff;

endmodule
